[design/rvx_pkg.sv]
// Package for the RV32I execute unit: opcode and function codes, constants
// and the struct that carries one executed item from the ALU to the pipeline.
// No dependencies.
package rvx_pkg;

	localparam logic [6:0] OPC_LOAD    = 7'h03;
	localparam logic [6:0] OPC_OPIMM   = 7'h13;
	localparam logic [6:0] OPC_AUIPC   = 7'h17;
	localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
	localparam logic [6:0] OPC_STORE   = 7'h23;
	localparam logic [6:0] OPC_OP      = 7'h33;
	localparam logic [6:0] OPC_LUI     = 7'h37;
	localparam logic [6:0] OPC_OP32    = 7'h3B;
	localparam logic [6:0] OPC_BRANCH  = 7'h63;
	localparam logic [6:0] OPC_JALR    = 7'h67;
	localparam logic [6:0] OPC_JAL     = 7'h6F;
	localparam logic [6:0] OPC_SYSTEM  = 7'h73;

	localparam logic [6:0] F7_NORMAL = 7'd0;
	localparam logic [6:0] F7_ALT    = 7'd32;

	localparam logic [2:0] LD_B  = 3'd0;
	localparam logic [2:0] LD_H  = 3'd1;
	localparam logic [2:0] LD_BU = 3'd4;
	localparam logic [2:0] LD_HU = 3'd5;

	localparam logic [31:0] PC_STEP   = 32'd4;
	localparam logic [31:0] EXIT_CODE = 32'd10;
	localparam logic [4:0]  REG_A0    = 5'd10;
	localparam logic [4:0]  REG_ZERO  = 5'd0;

	typedef struct packed {
		logic [31:0] npc;
		logic        wr;
		logic [31:0] val;
		logic        halt;
		logic        ld;
		logic        st;
		logic [2:0]  st_bytes;
		logic [31:0] addr;
	} exec_res_t;

endpackage

[design/rvx_if.sv]
// Handshake channels of the RV32I execute unit: the instruction channel and
// the result channel. Depends on nothing.
interface rvx_instr_if;
	logic        valid;
	logic        ready;
	logic [6:0]  major_opcode;
	logic [2:0]  minor_function;
	logic [6:0]  extra_function;
	logic [4:0]  dest_index;
	logic [4:0]  src_a_index;
	logic [4:0]  src_b_index;
	logic signed [31:0] imm_value;

	modport source (output valid, major_opcode, minor_function, extra_function,
		dest_index, src_a_index, src_b_index, imm_value, input ready);
	modport sink (input valid, major_opcode, minor_function, extra_function,
		dest_index, src_a_index, src_b_index, imm_value, output ready);
endinterface

interface rvx_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_pc;
	logic        reg_written;
	logic [4:0]  written_index;
	logic [31:0] written_value;
	logic        halted;

	modport source (output valid, next_pc, reg_written, written_index, written_value,
		halted, input ready);
	modport sink (input valid, next_pc, reg_written, written_index, written_value,
		halted, output ready);
endinterface

[design/rvx_regfile.sv]
// Register file: 32 x 32 bits, two registered read ports, one write port.
// Uses rvx_pkg; valid bits make never-written registers read as zero.
module rvx_regfile
	import rvx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  ra_idx,
	input  logic [4:0]  rb_idx,
	output logic [31:0] ra_data,
	output logic [31:0] rb_data,
	input  logic        we,
	input  logic [4:0]  wa_idx,
	input  logic [31:0] wdata
);

	logic [31:0] mem [32];
	logic [31:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we && wa_idx != REG_ZERO) begin
			valid_q[wa_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we && wa_idx != REG_ZERO) begin
			mem[wa_idx] <= wdata;
		end
	end

	// Write-first: a write on the same edge is seen by the read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (we && wa_idx == ra_idx && wa_idx != REG_ZERO) ra_data <= wdata;
			else ra_data <= valid_q[ra_idx] ? mem[ra_idx] : '0;
			if (we && wa_idx == rb_idx && wa_idx != REG_ZERO) rb_data <= wdata;
			else rb_data <= valid_q[rb_idx] ? mem[rb_idx] : '0;
		end
	end

endmodule

[design/rvx_dmem.sv]
// Byte data memory in four interleaved banks, one 32-bit unaligned access per
// cycle with wrap at the top. Uses rvx_pkg; read data is registered.
module rvx_dmem
	import rvx_pkg::*;
#(
	parameter int ADDR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic                 wr_en,
	input  logic [2:0]           wr_bytes,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [31:0]          wdata,
	output logic [31:0]          rdata
);

	localparam int ROW_BITS = ADDR_BITS - 2;
	localparam int DEPTH    = 1 << ROW_BITS;

	logic [1:0] off;
	logic [1:0] off_q;
	logic [7:0] bank_q [4];

	assign off = addr[1:0];

	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [7:0]          mem [DEPTH];
		logic [ROW_BITS-1:0] row;
		logic [1:0]          bidx;
		logic                bwe;

		// Banks below the offset hold bytes of the next row.
		assign row  = addr[ADDR_BITS-1:2] + ROW_BITS'(k < off);
		assign bidx = 2'(k) - off;
		assign bwe  = wr_en && ({1'b0, bidx} < wr_bytes);

		always_ff @(posedge clk) begin
			if (bwe) begin
				mem[row] <= wdata[8*bidx +: 8];
			end
			if (rd_en) begin
				bank_q[k] <= mem[row];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			off_q <= off;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rdata[8*i +: 8] = bank_q[2'(off_q + 2'(i))];
		end
	end

endmodule

[design/rvx_alu.sv]
// Combinational execute logic for one decoded RV32I instruction: ALU, branch,
// jump, load/store address and ecall. Uses rvx_pkg.
module rvx_alu
	import rvx_pkg::*;
(
	input  logic [6:0]  op,
	input  logic [2:0]  f3,
	input  logic [6:0]  f7,
	input  logic [4:0]  rd,
	input  logic [31:0] imm,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] a0,
	input  logic [31:0] pc,
	output exec_res_t   res
);

	logic [31:0] pc4;
	logic [6:0]  hi7;
	logic [4:0]  sh;
	logic [4:0]  bsh;
	logic        br_known;
	logic        take;

	assign pc4 = pc + PC_STEP;
	assign hi7 = imm[11:5];
	assign sh  = imm[4:0];
	assign bsh = b[4:0];

	always_comb begin
		res          = '0;
		res.npc      = pc;
		res.addr     = a + imm;
		br_known     = 1'b1;
		take         = 1'b0;
		case (op)
			OPC_LOAD: begin
				res.npc = pc4;
				res.wr  = f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6};
				res.ld  = res.wr;
			end
			OPC_OPIMM: begin
				res.npc = pc4;
				res.wr  = 1'b1;
				case (f3)
					3'd0: res.val = a + imm;
					3'd1: if (hi7 == F7_NORMAL) res.val = a << sh; else res.wr = 1'b0;
					3'd2: res.val = 32'($signed(a) < $signed(imm));
					3'd3: res.val = 32'(a < imm);
					3'd4: res.val = a ^ imm;
					3'd5: begin
						if (hi7 == F7_NORMAL) res.val = a >> sh;
						else if (hi7 == F7_ALT) res.val = $signed(a) >>> sh;
						else res.wr = 1'b0;
					end
					3'd6: res.val = a | imm;
					default: res.val = a & imm;
				endcase
			end
			OPC_AUIPC: begin
				res.npc = pc4;
				res.wr  = 1'b1;
				res.val = pc + imm;
			end
			OPC_OPIMM32: begin
				res.npc = pc4;
				res.wr  = 1'b1;
				if (f3 == 3'd0) res.val = a + imm;
				else if (f3 == 3'd1) res.val = a << sh;
				else if (f3 == 3'd5 && f7 == F7_NORMAL) res.val = a >> sh;
				else if (f3 == 3'd5 && f7 == F7_ALT) res.val = $signed(a) >>> sh;
				else res.wr = 1'b0;
			end
			OPC_STORE: begin
				res.npc = pc4;
				res.st  = f3 inside {3'd0, 3'd1, 3'd2};
				case (f3)
					3'd0: res.st_bytes = 3'd1;
					3'd1: res.st_bytes = 3'd2;
					default: res.st_bytes = 3'd4;
				endcase
			end
			OPC_OP: begin
				res.npc = pc4;
				res.wr  = 1'b1;
				if (f7 == F7_NORMAL) begin
					case (f3)
						3'd0: res.val = a + b;
						3'd1: res.val = a << bsh;
						3'd2: res.val = 32'($signed(a) < $signed(b));
						3'd3: res.val = 32'(a < b);
						3'd4: res.val = a ^ b;
						3'd5: res.val = a >> bsh;
						3'd6: res.val = a | b;
						default: res.val = a & b;
					endcase
				end else if (f7 == F7_ALT && f3 == 3'd0) res.val = a - b;
				else if (f7 == F7_ALT && f3 == 3'd5) res.val = $signed(a) >>> bsh;
				else res.wr = 1'b0;
			end
			OPC_LUI: begin
				res.npc = pc4;
				res.wr  = 1'b1;
				res.val = imm;
			end
			OPC_OP32: begin
				res.npc = pc4;
				res.wr  = 1'b1;
				if (f3 == 3'd0 && f7 == F7_NORMAL) res.val = a + b;
				else if (f3 == 3'd0 && f7 == F7_ALT) res.val = a - b;
				else if (f3 == 3'd1 && f7 == F7_NORMAL) res.val = a << bsh;
				else if (f3 == 3'd5 && f7 == F7_NORMAL) res.val = a >> bsh;
				else if (f3 == 3'd5 && f7 == F7_ALT) res.val = $signed(a) >>> bsh;
				else res.wr = 1'b0;
			end
			OPC_BRANCH: begin
				case (f3)
					3'd0: take = (a == b);
					3'd1: take = (a != b);
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = !($signed(a) < $signed(b));
					3'd6: take = a < b;
					3'd7: take = a >= b;
					default: br_known = 1'b0;
				endcase
				if (br_known) res.npc = take ? pc + imm : pc4;
			end
			OPC_JALR: begin
				if (f3 == 3'd0) begin
					res.wr  = 1'b1;
					res.val = pc4;
					res.npc = {res.addr[31:1], 1'b0};
				end
			end
			OPC_JAL: begin
				res.wr  = 1'b1;
				res.val = pc4;
				res.npc = pc + imm;
			end
			OPC_SYSTEM: begin
				if (f3 == 3'd0 && hi7 == F7_NORMAL) begin
					if (a0 == EXIT_CODE) res.halt = 1'b1;
					else res.npc = pc4;
				end
			end
			default: ;
		endcase
		if (rd == REG_ZERO) begin
			res.wr = 1'b0;
			res.ld = 1'b0;
		end
		if (!res.wr) res.val = '0;
	end

endmodule

[design/rv32i_execute_unit.sv]
// Top level of the RV32I execute unit: two-stage pipeline around the register
// file, the byte data memory and the execute logic. Uses rvx_pkg, rvx_if,
// rvx_regfile, rvx_dmem and rvx_alu.
//
//  Channel        Direction  Handshake        Carries
//  instr          in         valid/ready      one decoded instruction per item
//  result         out        valid/ready      next pc, register write, halt
//  start_address  in         start_address_we unused; does not set the pc
//
// One item enters per cycle while s1 is free or moving. An item waits in the
// execute stage (s1), where it reads forwarded operands, updates the program
// counter and issues its store or load, then sits in the result stage (s2)
// until the result is taken; load data comes from the memory's read register
// there. A stalled result holds s2 and s1, and the instruction channel keeps
// taking items as long as s1 is free or moving. Reset clears the pipeline
// valid bits, the register file valid bits and the program counter; the data
// memory is not cleared.
module rv32i_execute_unit
	import rvx_pkg::*;
#(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	rvx_instr_if.sink    instr,
	rvx_result_if.source result,
	input  logic         start_address_we,
	input  logic [31:0]  start_address
);

	// The program counter comes out of reset at PC_RESET, zero; start_address is
	// not used, so writes to it do not move a running counter.
	localparam logic [31:0] PC_RESET = 32'd0;

	logic        in_fire;
	logic        adv_s1;
	logic        out_fire;

	logic        valid_s1;
	logic [6:0]  op_s1;
	logic [2:0]  f3_s1;
	logic [6:0]  f7_s1;
	logic [4:0]  rd_s1;
	logic [4:0]  rs1_s1;
	logic [4:0]  rs2_s1;
	logic [31:0] imm_s1;
	logic [31:0] ra_s1;
	logic [31:0] rb_s1;

	logic        valid_s2;
	logic [31:0] npc_s2;
	logic        wr_s2;
	logic [4:0]  idx_s2;
	logic [31:0] val_s2;
	logic        ld_s2;
	logic [2:0]  ldf3_s2;
	logic        halt_s2;

	logic [31:0] pc_q;
	logic [31:0] a0_q;

	logic [31:0] opa;
	logic [31:0] opb;
	logic [31:0] a0_fwd;
	logic [31:0] mem_rdata;
	logic [31:0] ld_val;
	logic [31:0] wb_val;
	logic        rf_we;
	exec_res_t   ex;

	function automatic logic [31:0] imm_value_u(input logic signed [31:0] v);
		return 32'(v);
	endfunction

	assign out_fire     = result.valid && result.ready;
	assign adv_s1       = valid_s1 && (!valid_s2 || result.ready);
	assign instr.ready  = !valid_s1 || adv_s1;
	assign in_fire      = instr.valid && instr.ready;

	// Register file write happens when the result leaves s2.
	assign rf_we = out_fire && wr_s2;

	rvx_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.ra_idx  (instr.src_a_index),
		.rb_idx  (instr.src_b_index),
		.ra_data (ra_s1),
		.rb_data (rb_s1),
		.we      (rf_we),
		.wa_idx  (idx_s2),
		.wdata   (wb_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= instr.major_opcode;
			f3_s1  <= instr.minor_function;
			f7_s1  <= instr.extra_function;
			rd_s1  <= instr.dest_index;
			rs1_s1 <= instr.src_a_index;
			rs2_s1 <= instr.src_b_index;
			imm_s1 <= imm_value_u(instr.imm_value);
		end
	end

	// The item in s2 has not written the register file yet, so its value is
	// forwarded to the operands of the item in s1.
	always_comb begin
		opa    = (valid_s2 && wr_s2 && idx_s2 == rs1_s1) ? wb_val : ra_s1;
		opb    = (valid_s2 && wr_s2 && idx_s2 == rs2_s1) ? wb_val : rb_s1;
		a0_fwd = (valid_s2 && wr_s2 && idx_s2 == REG_A0) ? wb_val : a0_q;
	end

	rvx_alu u_alu (
		.op  (op_s1),
		.f3  (f3_s1),
		.f7  (f7_s1),
		.rd  (rd_s1),
		.imm (imm_s1),
		.a   (opa),
		.b   (opb),
		.a0  (a0_fwd),
		.pc  (pc_q),
		.res (ex)
	);

	rvx_dmem #(
		.ADDR_BITS (MEM_ADDR_BITS)
	) u_dmem (
		.clk      (clk),
		.rd_en    (adv_s1 && ex.ld),
		.wr_en    (adv_s1 && ex.st),
		.wr_bytes (ex.st_bytes),
		.addr     (ex.addr[MEM_ADDR_BITS-1:0]),
		.wdata    (opb),
		.rdata    (mem_rdata)
	);

	// Program counter and a copy of a0 for ecall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_RESET;
			a0_q <= '0;
		end else begin
			if (adv_s1) pc_q <= ex.npc;
			if (rf_we && idx_s2 == REG_A0) a0_q <= wb_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_fire) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			npc_s2  <= ex.npc;
			wr_s2   <= ex.wr;
			idx_s2  <= ex.wr ? rd_s1 : REG_ZERO;
			val_s2  <= ex.val;
			ld_s2   <= ex.ld;
			ldf3_s2 <= f3_s1;
			halt_s2 <= ex.halt;
		end
	end

	// Load extension from the registered memory word.
	always_comb begin
		case (ldf3_s2)
			LD_B:    ld_val = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
			LD_H:    ld_val = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
			LD_BU:   ld_val = {24'd0, mem_rdata[7:0]};
			LD_HU:   ld_val = {16'd0, mem_rdata[15:0]};
			default: ld_val = mem_rdata;
		endcase
	end

	assign wb_val = ld_s2 ? ld_val : val_s2;

	assign result.valid         = valid_s2;
	assign result.next_pc       = npc_s2;
	assign result.reg_written   = wr_s2;
	assign result.written_index = idx_s2;
	assign result.written_value = wb_val;
	assign result.halted        = halt_s2;

endmodule

[design/rvx_checker.sv]
// Port-level checks for the RV32I execute unit, attached by bind.
// Depends on rvx_pkg and the top level's channel ports.
module rvx_checker
	import rvx_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        reg_written,
	input logic [4:0]  written_index,
	input logic [31:0] written_value,
	input logic        halted
);

	// A result without a write reports zero index and zero value.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !reg_written) |-> (written_index == REG_ZERO && written_value == '0))
		else $error("result without write carries nonzero index or value");

	// Register x0 is never reported as written.
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reg_written) |-> (written_index != REG_ZERO))
		else $error("write to x0 reported");

	// A halting ecall never writes a register.
	a_halt_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && halted) |-> !reg_written)
		else $error("halt together with register write");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn while stalled");

endmodule

bind rv32i_execute_unit rvx_checker u_rvx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.reg_written   (result.reg_written),
	.written_index (result.written_index),
	.written_value (result.written_value),
	.halted        (result.halted)
);
